### design/ctc_pkg.sv
package ctc_pkg;

    localparam int unsigned CTC_SLOTS_DEF   = 8;
    localparam logic [63:0] CTC_TMO_RESET   = 64'd5000000000;
    localparam logic [31:0] CTC_ID_RESET    = 32'hFFFF_FFFF;

    // Result event codes
    localparam logic [2:0] EV_HIT   = 3'd0;
    localparam logic [2:0] EV_NEW   = 3'd1;
    localparam logic [2:0] EV_FULL  = 3'd2;
    localparam logic [2:0] EV_EVICT = 3'd3;
    localparam logic [2:0] EV_NONE  = 3'd4;

    // Request commands
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP
    } ctc_state_t;

    // Running priority flags handed from cell to cell
    typedef struct packed {
        logic hit;
        logic free;
        logic exp;
        logic exp2;
    } ctc_chain_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic lookup;
        logic commit;
        logic any_hit;
        logic evict;
        logic tmo_zero;
    } ctc_cell_ctrl_t;

    // Per-cell selection flags back to the sequencer
    typedef struct packed {
        logic hit_first;
        logic ins_sel;
        logic exp_first;
    } ctc_cell_stat_t;

endpackage

### design/ctc_in_if.sv
interface ctc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] src_address;
    logic [15:0] src_port;
    logic [63:0] now_ns;

    modport source (output valid, command, src_address, src_port, now_ns, input ready);
    modport sink   (input valid, command, src_address, src_port, now_ns, output ready);
endinterface

### design/ctc_out_if.sv
interface ctc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [2:0]  slot_index;
    logic [31:0] conn_id;
    logic [3:0]  active_count;
    logic        last_result;

    modport source (output valid, event_kind, slot_index, conn_id, active_count, last_result,
                    input ready);
    modport sink   (input valid, event_kind, slot_index, conn_id, active_count, last_result,
                    output ready);
endinterface

### design/ctc_cell.sv
module ctc_cell
    import ctc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ctc_cell_ctrl_t ctrl,
    input  logic [31:0]    key_address,
    input  logic [15:0]    key_port,
    input  logic [63:0]    now,
    input  logic [63:0]    timeout,
    input  logic [31:0]    new_id,
    input  ctc_chain_t     chain_in,
    output ctc_chain_t     chain_out,
    output ctc_cell_stat_t stat,
    output logic [31:0]    id
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] address_reg;
    logic [15:0] port_reg;
    logic [31:0] id_reg;
    logic [63:0] seen_reg;

    logic        match;
    logic        hit_first;
    logic        free_here;
    logic        free_first;
    logic        ins_sel;
    logic        touched;
    logic [63:0] age;
    logic        expired;
    logic        exp_first;

    always_comb
    begin
        match      = valid_reg && (address_reg == key_address) && (port_reg == key_port);
        hit_first  = match && !chain_in.hit;
        free_here  = !valid_reg;
        free_first = free_here && !chain_in.free;
        ins_sel    = !ctrl.any_hit && free_first;
        touched    = ctrl.lookup && (hit_first || ins_sel);
        age        = now - seen_reg;
        // a slot stamped in this cycle has age zero
        expired    = touched ? ctrl.tmo_zero : (valid_reg && (age >= timeout));
        exp_first  = expired && !chain_in.exp;

        chain_out.hit  = chain_in.hit  || match;
        chain_out.free = chain_in.free || free_here;
        chain_out.exp  = chain_in.exp  || expired;
        chain_out.exp2 = chain_in.exp2 || (expired && chain_in.exp);

        stat.hit_first = hit_first;
        stat.ins_sel   = ins_sel;
        stat.exp_first = exp_first;
        id             = id_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.commit && ins_sel)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.evict && exp_first)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit && ins_sel)
        begin
            address_reg <= key_address;
            port_reg    <= key_port;
            id_reg      <= new_id;
        end
        if (ctrl.commit && (hit_first || ins_sel))
        begin
            seen_reg <= now;
        end
    end

endmodule

### design/connection_table_with_aging.sv
// Connection table with idle aging. Each request carries a command (packet
// or sweep only), a source address and port and the current time in ns.
// A packet looks its key up among the valid slots: a hit refreshes the
// slot's last-seen time, a miss takes the lowest free slot with the next
// client id, and a full table rejects. Then every valid slot idle for at
// least the timeout is evicted, one result each, lowest slot first; the
// final result of a request has last_result set. A request is first
// captured, then looked up across the cell row; each eviction then
// follows as a result of its own, and any result waits while the output
// register is still held by the receiver. The timeout may be written
// only while the block is idle.
module connection_table_with_aging
    import ctc_pkg::*;
#(
    parameter int unsigned SLOTS = CTC_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        timeout_we,
    input  logic [63:0] timeout_wdata,
    ctc_in_if.sink      request,
    ctc_out_if.source   result
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);

    ctc_state_t state_reg;
    ctc_state_t state_next;

    logic [63:0]      timeout_reg;
    logic [31:0]      id_counter_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic        cmd_reg;
    logic [31:0] address_reg;
    logic [15:0] port_reg;
    logic [63:0] now_reg;

    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [2:0]  out_slot_reg;
    logic [31:0] out_id_reg;
    logic [3:0]  out_count_reg;
    logic        out_last_reg;

    ctc_chain_t     chain [SLOTS+1];
    ctc_cell_ctrl_t ctrl;
    ctc_cell_stat_t stat [SLOTS];
    logic [31:0]    cell_id [SLOTS];
    logic [31:0]    new_id;

    logic             out_free;
    logic             accept;
    logic             emit;
    logic             insert;
    logic [2:0]       em_kind;
    logic [IDX_W-1:0] em_idx;
    logic [31:0]      em_id;
    logic [CNT_W-1:0] em_count;
    logic             em_last;

    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] exp_idx;
    logic [31:0]      hit_id;
    logic [31:0]      exp_id;

    logic [IDX_W+2:0] idx_ext;
    logic [CNT_W+3:0] cnt_ext;

    assign out_free = !out_valid_reg || result.ready;
    assign accept   = request.valid && request.ready;
    assign new_id   = id_counter_reg + 32'd1;

    assign chain[0] = '0;

    generate
        for (genvar i = 0; i < SLOTS; i++)
        begin : g_cell
            ctc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key_address (address_reg),
                .key_port    (port_reg),
                .now         (now_reg),
                .timeout     (timeout_reg),
                .new_id      (new_id),
                .chain_in    (chain[i]),
                .chain_out   (chain[i+1]),
                .stat        (stat[i]),
                .id          (cell_id[i])
            );
        end
    endgenerate

    // one-hot selections to slot numbers and ids
    always_comb
    begin
        hit_idx = '0;
        ins_idx = '0;
        exp_idx = '0;
        hit_id  = '0;
        exp_id  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (stat[i].hit_first)
            begin
                hit_idx = hit_idx | IDX_W'(i);
                hit_id  = hit_id | cell_id[i];
            end
            if (stat[i].ins_sel)
            begin
                ins_idx = ins_idx | IDX_W'(i);
            end
            if (stat[i].exp_first)
            begin
                exp_idx = exp_idx | IDX_W'(i);
                exp_id  = exp_id | cell_id[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (cmd_reg == CMD_PACKET)
                begin
                    if (out_free)
                    begin
                        state_next = chain[SLOTS].exp ? ST_SWEEP : ST_IDLE;
                    end
                end
                else if (chain[SLOTS].exp)
                begin
                    state_next = ST_SWEEP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (out_free && !chain[SLOTS].exp2)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request.ready = 1'b0;
        ctrl          = '0;
        ctrl.any_hit  = chain[SLOTS].hit;
        ctrl.tmo_zero = (timeout_reg == 64'd0);
        emit          = 1'b0;
        insert        = 1'b0;
        em_kind       = EV_NONE;
        em_idx        = '0;
        em_id         = '0;
        em_count      = count_reg;
        em_last       = 1'b1;
        count_next    = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
            end
            ST_LOOKUP:
            begin
                if (cmd_reg == CMD_PACKET)
                begin
                    ctrl.lookup = 1'b1;
                    ctrl.commit = out_free;
                    emit        = out_free;
                    em_last     = !chain[SLOTS].exp;
                    if (chain[SLOTS].hit)
                    begin
                        em_kind = EV_HIT;
                        em_idx  = hit_idx;
                        em_id   = hit_id;
                    end
                    else if (chain[SLOTS].free)
                    begin
                        em_kind  = EV_NEW;
                        em_idx   = ins_idx;
                        em_id    = new_id;
                        em_count = count_reg + CNT_W'(1);
                        insert   = out_free;
                    end
                    else
                    begin
                        em_kind = EV_FULL;
                    end
                    if (out_free)
                    begin
                        count_next = em_count;
                    end
                end
                else if (!chain[SLOTS].exp)
                begin
                    // sweep with nothing to evict
                    emit = out_free;
                end
            end
            ST_SWEEP:
            begin
                ctrl.evict = out_free;
                emit       = out_free;
                em_kind    = EV_EVICT;
                em_idx     = exp_idx;
                em_id      = exp_id;
                em_count   = count_reg - CNT_W'(1);
                em_last    = !chain[SLOTS].exp2;
                if (out_free)
                begin
                    count_next = em_count;
                end
            end
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    assign idx_ext = {3'b000, em_idx};
    assign cnt_ext = {4'b0000, em_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            timeout_reg    <= CTC_TMO_RESET;
            id_counter_reg <= CTC_ID_RESET;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (timeout_we)
            begin
                timeout_reg <= timeout_wdata;
            end
            if (insert)
            begin
                id_counter_reg <= new_id;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= request.command;
            address_reg <= request.src_address;
            port_reg    <= request.src_port;
            now_reg     <= request.now_ns;
        end
        if (emit)
        begin
            out_kind_reg  <= em_kind;
            out_slot_reg  <= idx_ext[2:0];
            out_id_reg    <= em_id;
            out_count_reg <= cnt_ext[3:0];
            out_last_reg  <= em_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_kind   = out_kind_reg;
    assign result.slot_index   = out_slot_reg;
    assign result.conn_id      = out_id_reg;
    assign result.active_count = out_count_reg;
    assign result.last_result  = out_last_reg;

endmodule

### dv/connection_table_with_aging_tb.sv
module connection_table_with_aging_tb;
    import ctc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = CTC_SLOTS_DEF;
    localparam logic [63:0] ALL_ONES_NS = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [31:0] id;
        logic [3:0]  count;
        logic        is_last;
    } conn_event_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        timeout_we;
    logic [63:0] timeout_wdata;
    logic        take_ready = 1'b0;

    ctc_in_if  req_if ();
    ctc_out_if res_if ();

    assign res_if.ready = take_ready;

    connection_table_with_aging u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata),
        .request       (req_if),
        .result        (res_if)
    );

    always #5 clk = ~clk;

    // shadow copy of the connection table
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_addr  [NSLOT];
    logic [15:0] tbl_port  [NSLOT];
    logic [31:0] tbl_id    [NSLOT];
    logic [63:0] tbl_seen  [NSLOT];
    logic [3:0]  tbl_count;
    logic [31:0] id_issued;
    logic [63:0] idle_limit;

    conn_event_t pending_events [$];
    conn_event_t head_event;
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [63:0] wall_ns;

    function automatic void push_event(logic [2:0] kind, int slot, logic [31:0] id);
        conn_event_t ev;
        ev.kind    = kind;
        ev.slot    = slot[2:0];
        ev.id      = id;
        ev.count   = tbl_count;
        ev.is_last = 1'b0;
        pending_events.push_back(ev);
    endfunction

    function automatic void clear_table();
        for (int s = 0; s < NSLOT; s++)
        begin
            tbl_valid[s] = 1'b0;
            tbl_addr[s]  = '0;
            tbl_port[s]  = '0;
            tbl_id[s]    = '0;
            tbl_seen[s]  = '0;
        end
        tbl_count  = '0;
        id_issued  = CTC_ID_RESET;
        idle_limit = CTC_TMO_RESET;
    endfunction

    function automatic void predict_table_update(logic cmd, logic [31:0] addr,
                                                 logic [15:0] port, logic [63:0] now);
        int          hit_slot;
        int          free_slot;
        int          produced;
        logic [31:0] gone_id;
        hit_slot  = -1;
        free_slot = -1;
        produced  = 0;
        if (cmd == CMD_PACKET)
        begin
            for (int s = 0; s < NSLOT; s++)
                if (hit_slot < 0 && tbl_valid[s] && tbl_addr[s] == addr && tbl_port[s] == port)
                    hit_slot = s;
            if (hit_slot >= 0)
            begin
                tbl_seen[hit_slot] = now;
                push_event(EV_HIT, hit_slot, tbl_id[hit_slot]);
            end
            else
            begin
                if (tbl_count < NSLOT)
                    for (int s = 0; s < NSLOT; s++)
                        if (free_slot < 0 && !tbl_valid[s])
                            free_slot = s;
                if (free_slot < 0)
                    push_event(EV_FULL, 0, '0);
                else
                begin
                    id_issued            = id_issued + 32'd1;
                    tbl_valid[free_slot] = 1'b1;
                    tbl_addr[free_slot]  = addr;
                    tbl_port[free_slot]  = port;
                    tbl_id[free_slot]    = id_issued;
                    tbl_seen[free_slot]  = now;
                    tbl_count            = tbl_count + 4'd1;
                    push_event(EV_NEW, free_slot, id_issued);
                end
            end
            produced++;
        end
        // age is modular, so a time stamp in the future looks ancient
        for (int s = 0; s < NSLOT; s++)
        begin
            if (tbl_valid[s] && (now - tbl_seen[s]) >= idle_limit)
            begin
                gone_id      = tbl_id[s];
                tbl_valid[s] = 1'b0;
                tbl_addr[s]  = '0;
                tbl_port[s]  = '0;
                tbl_id[s]    = '0;
                tbl_seen[s]  = '0;
                if (tbl_count > 0)
                    tbl_count = tbl_count - 4'd1;
                push_event(EV_EVICT, s, gone_id);
                produced++;
            end
        end
        if (produced == 0)
            push_event(EV_NONE, 0, '0);
        pending_events[pending_events.size() - 1].is_last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
        take_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && take_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_kind: expected no result, got %0h", res_if.event_kind);
                errors++;
            end
            else
            begin
                head_event = pending_events.pop_front();
                check_field("event_kind", 64'(head_event.kind), 64'(res_if.event_kind));
                check_field("slot_index", 64'(head_event.slot), 64'(res_if.slot_index));
                check_field("conn_id", 64'(head_event.id), 64'(res_if.conn_id));
                check_field("active_count", 64'(head_event.count),
                            64'(res_if.active_count));
                check_field("last_result", 64'(head_event.is_last),
                            64'(res_if.last_result));
            end
        end
    end

    // valid stays up between back-to-back requests; it drops only for a gap
    task automatic send_request(logic cmd, logic [31:0] addr, logic [15:0] port,
                                logic [63:0] now);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.src_address <= addr;
        req_if.src_port    <= port;
        req_if.now_ns      <= now;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_table_update(cmd, addr, port, now);
    endtask

    task automatic settle_table();
        req_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(logic [63:0] value);
        settle_table();
        timeout_we    <= 1'b1;
        timeout_wdata <= value;
        @(posedge clk);
        idle_limit = value;
        timeout_we <= 1'b0;
    endtask

    task automatic test_insert_refresh_expire();
        send_request(CMD_PACKET, 32'h0, 16'h0, 64'd0);
        send_request(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 64'd100);
        send_request(CMD_PACKET, 32'h0, 16'h0, 64'd200);
        // same address, other port: a separate connection
        send_request(CMD_PACKET, 32'h0, 16'hFFFF, 64'd300);
        send_request(CMD_SWEEP, 32'h0, 16'h0, 64'd5_000_000_100);
        send_request(CMD_SWEEP, 32'hFFFF_FFFF, 16'hFFFF, 64'd5_000_000_300);
    endtask

    task automatic test_empty_sweep();
        send_request(CMD_SWEEP, 32'h1234_5678, 16'h9ABC, 64'd0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NSLOT; i++)
            send_request(CMD_PACKET, 32'h0A00_0000 | 32'(i), 16'h8000 | 16'(i),
                         64'd1000 + 64'(i));
        send_request(CMD_PACKET, 32'h5555_AAAA, 16'h5A5A, 64'd1500);
        send_request(CMD_PACKET, 32'h0A00_0003, 16'h8003, 64'd2000);
        // rejected while full, then every slot ages out on the same request
        send_request(CMD_PACKET, 32'hAAAA_5555, 16'hA5A5, 64'd20_000_000_000);
    endtask

    task automatic test_zero_timeout();
        write_timeout(64'd0);
        send_request(CMD_PACKET, 32'hC0A8_0001, 16'd443, 64'd777);
        send_request(CMD_SWEEP, 32'h0, 16'h0, 64'd778);
    endtask

    task automatic test_wrapped_age();
        write_timeout(ALL_ONES_NS);
        send_request(CMD_PACKET, 32'h7F00_0001, 16'd80, 64'd10);
        send_request(CMD_SWEEP, 32'h0, 16'h0, 64'd9);
        write_timeout(CTC_TMO_RESET);
        send_request(CMD_PACKET, 32'h8000_0000, 16'h0001, ALL_ONES_NS);
        send_request(CMD_SWEEP, 32'h0, 16'h0, 64'd0);
        send_request(CMD_SWEEP, 32'h0, 16'h0, ALL_ONES_NS - 1);
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, logic [63:0] tmo,
                                       int unsigned max_step, int count);
        logic [31:0] pool_addr [10];
        logic [15:0] pool_port [10];
        logic [31:0] addr;
        logic [15:0] port;
        logic        cmd;
        int unsigned pick;
        write_timeout(tmo);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        // more keys than slots so the table fills; some keys share an address
        for (int k = 0; k < 10; k++)
        begin
            pool_addr[k] = (k % 3 == 2) ? pool_addr[k - 1] : $urandom;
            pool_port[k] = 16'($urandom_range(16'hFFFF));
        end
        wall_ns = {$urandom, $urandom};
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            cmd  = CMD_PACKET;
            addr = pool_addr[n % 10];
            port = pool_port[n % 10];
            if (pick < 8)
            begin
                cmd  = CMD_SWEEP;
                addr = $urandom;
                port = 16'($urandom_range(16'hFFFF));
            end
            else if (pick < 18)
            begin
                addr = $urandom;
                port = 16'($urandom_range(16'hFFFF));
            end
            else
            begin
                pick = $urandom_range(9);
                addr = pool_addr[pick];
                port = pool_port[pick];
            end
            if ($urandom_range(99) < 5)
                wall_ns = wall_ns - $urandom_range(1, max_step * 2 + 1);
            else
                wall_ns = wall_ns + $urandom_range(0, max_step);
            send_request(cmd, addr, port, wall_ns);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        timeout_we         = 1'b0;
        timeout_wdata      = '0;
        req_if.valid       = 1'b0;
        req_if.command     = CMD_PACKET;
        req_if.src_address = '0;
        req_if.src_port    = '0;
        req_if.now_ns      = '0;
        clear_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_insert_refresh_expire();
        test_empty_sweep();
        test_full_table();
        test_zero_timeout();
        test_wrapped_age();
        test_random_traffic(0, 0, 64'd1000, 400, 51);
        test_random_traffic(74, 0, 64'd300, 150, 51);
        test_random_traffic(0, 74, 64'd5_000_000_000, 2_000_000_000, 51);
        test_random_traffic(33, 33, 64'd40, 25, 51);

        settle_table();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[connection_table_with_aging] OK");
        else
            $display("[connection_table_with_aging] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[connection_table_with_aging] ERROR");
        $finish;
    end

endmodule

### sim.f
design/ctc_pkg.sv
design/ctc_in_if.sv
design/ctc_out_if.sv
design/ctc_cell.sv
design/connection_table_with_aging.sv
dv/connection_table_with_aging_tb.sv
